// File: src/frame_rate_statistics_unit_macros.svh
`ifndef FRAME_RATE_STATISTICS_UNIT_MACROS_SVH
`define FRAME_RATE_STATISTICS_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FRSU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FRSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/frsu_pkg.sv
`timescale 1ns / 1ps

package frsu_pkg;

	localparam int TIME_W  = 32;
	localparam int CNT_W   = 24;
	localparam int JIT_W   = 48;
	localparam int OUT_W   = 28;
	localparam int IVL_W   = 24;
	localparam int IDEAL_W = 20;
	localparam int PROD_W  = CNT_W + OUT_W;
	localparam int DVD_W   = 56;
	localparam int DVS_W   = TIME_W;
	localparam int STEP_W  = 6;

	localparam logic [IDEAL_W-1:0] IDEAL_RST = 20'd16667;
	localparam logic [OUT_W-1:0]   Q8_MICROS = 28'd256000000;
	localparam logic [OUT_W-1:0]   OUT_MAX   = '1;

	// 256e6 parked in the top half: only OUT_W quotient bits need computing
	localparam logic [DVD_W-1:0]  DVD_Q8      = {Q8_MICROS, {(DVD_W - OUT_W){1'b0}}};
	localparam logic [STEP_W-1:0] STEPS_SHORT = STEP_W'(DVD_W - OUT_W);
	localparam logic [STEP_W-1:0] STEPS_LONG  = STEP_W'(DVD_W);

	localparam logic ACT_FRAME  = 1'b0;
	localparam logic ACT_REPORT = 1'b1;

endpackage

// File: src/frame_rate_statistics_unit.sv
`timescale 1ns / 1ps

// Frame rate statistics. A frame item (action 0) adds one frame interval to the
// count, time sum, shortest/longest time and jitter sum; a report item (action 1)
// returns average, minimum and maximum fps and mean jitter in unsigned Q.8 and
// clears the accumulators. All division is done by one restoring divider that
// produces one quotient bit per cycle, so in_stall is high while an item is
// worked on: a frame takes one division, plus one more when the ideal period's
// fps has to be recomputed (first frame after reset or after a write of the
// ideal period); a report takes two 28-step and two 56-step divisions, or none
// when no frame has been seen. A finished report waits in its own register
// until the output register is free, and the output register holds a result
// while further items are accepted.
module frame_rate_statistics_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [frsu_pkg::IDEAL_W-1:0] cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         action,
	input  logic [frsu_pkg::IVL_W-1:0]   frame_interval_us,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [frsu_pkg::OUT_W-1:0]   average_fps,
	output logic [frsu_pkg::OUT_W-1:0]   minimum_fps,
	output logic [frsu_pkg::OUT_W-1:0]   maximum_fps,
	output logic [frsu_pkg::OUT_W-1:0]   jitter_fps
);
	import frsu_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_F_IDEAL,
		S_F_T,
		S_F_JIT,
		S_R_MIN,
		S_R_MAX,
		S_R_AVG,
		S_R_JIT,
		S_R_OUT
	} state_t;

	state_t               state_q;
	logic [IDEAL_W-1:0]   ideal_q;
	logic [OUT_W-1:0]     ideal_fps_q;
	logic                 ideal_ok_q;
	logic                 started_q;
	logic [CNT_W-1:0]     count_q;
	logic [TIME_W-1:0]    sum_q;
	logic [TIME_W-1:0]    short_q;
	logic [TIME_W-1:0]    long_q;
	logic [JIT_W-1:0]     jit_q;
	logic [IVL_W-1:0]     t_q;
	logic [PROD_W-1:0]    prod_q;
	logic [OUT_W-1:0]     b_q;
	logic [OUT_W-1:0]     res_avg_q, res_min_q, res_max_q, res_jit_q;
	logic [OUT_W-1:0]     avg_out_q, min_out_q, max_out_q, jit_out_q;
	logic                 out_valid_q;

	// shared divider
	logic [DVD_W-1:0]     dq_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [STEP_W-1:0]    cnt_q;

	logic                 accept;
	logic                 out_free;
	logic                 div_done;
	logic [IDEAL_W-1:0]   ideal_eff;
	logic [IVL_W-1:0]     t_eff;
	logic [DVS_W:0]       rem_sh;
	logic                 rem_ge;
	logic [DVS_W:0]       rem_sub;
	logic [OUT_W-1:0]     q_sat;
	logic [TIME_W:0]      sum_add;
	logic [OUT_W-1:0]     jit_diff;
	logic [JIT_W:0]       jit_add;

	logic                 ld_en;
	logic [DVD_W-1:0]     ld_dvd;
	logic [DVS_W-1:0]     ld_dvs;
	logic [STEP_W-1:0]    ld_steps;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign div_done  = (cnt_q == '0);

	assign ideal_eff = (ideal_q == '0) ? IDEAL_W'(1) : ideal_q;
	assign t_eff     = !started_q ? IVL_W'(ideal_eff) :
	                   (frame_interval_us == '0) ? IVL_W'(1) : frame_interval_us;

	assign rem_sh    = {rem_q, dq_q[DVD_W-1]};
	assign rem_ge    = (rem_sh >= {1'b0, dvs_q});
	assign rem_sub   = rem_sh - {1'b0, dvs_q};
	assign q_sat     = (|dq_q[DVD_W-1:OUT_W]) ? OUT_MAX : dq_q[OUT_W-1:0];

	assign sum_add   = {1'b0, sum_q} + (TIME_W + 1)'(t_eff);
	assign jit_diff  = (ideal_fps_q >= b_q) ? (ideal_fps_q - b_q) : (b_q - ideal_fps_q);
	assign jit_add   = {1'b0, jit_q} + (JIT_W + 1)'(jit_diff);

	// next division to start, if any
	always_comb begin
		ld_en    = 1'b0;
		ld_dvd   = DVD_Q8;
		ld_dvs   = '0;
		ld_steps = STEPS_SHORT;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (action == ACT_FRAME) begin
						ld_en  = 1'b1;
						ld_dvs = ideal_ok_q ? DVS_W'(t_eff) : DVS_W'(ideal_eff);
					end else if (count_q != '0) begin
						ld_en  = 1'b1;
						ld_dvs = long_q;
					end
				end
			end
			S_F_IDEAL: begin
				if (div_done) begin
					ld_en  = 1'b1;
					ld_dvs = DVS_W'(t_q);
				end
			end
			S_R_MIN: begin
				if (div_done) begin
					ld_en  = 1'b1;
					ld_dvs = short_q;
				end
			end
			S_R_MAX: begin
				if (div_done) begin
					ld_en    = 1'b1;
					ld_dvd   = DVD_W'(prod_q);
					ld_dvs   = sum_q;
					ld_steps = STEPS_LONG;
				end
			end
			S_R_AVG: begin
				if (div_done) begin
					ld_en    = 1'b1;
					ld_dvd   = DVD_W'(jit_q);
					ld_dvs   = DVS_W'(count_q);
					ld_steps = STEPS_LONG;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ld_en) begin
			cnt_q <= ld_steps;
		end else if (!div_done) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// restoring division, one quotient bit per cycle shifted in at the bottom
	always_ff @(posedge clk) begin
		if (ld_en) begin
			dq_q  <= ld_dvd;
			rem_q <= '0;
			dvs_q <= ld_dvs;
		end else if (!div_done) begin
			dq_q  <= {dq_q[DVD_W-2:0], rem_ge};
			rem_q <= rem_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ideal_q     <= IDEAL_RST;
			ideal_fps_q <= '0;
			ideal_ok_q  <= 1'b0;
			started_q   <= 1'b0;
			count_q     <= '0;
			sum_q       <= '0;
			short_q     <= '1;
			long_q      <= '0;
			jit_q       <= '0;
			t_q         <= '0;
			prod_q      <= '0;
			b_q         <= '0;
			res_avg_q   <= '0;
			res_min_q   <= '0;
			res_max_q   <= '0;
			res_jit_q   <= '0;
			avg_out_q   <= '0;
			min_out_q   <= '0;
			max_out_q   <= '0;
			jit_out_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				ideal_q    <= cfg_wr_data;
				ideal_ok_q <= 1'b0;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (action == ACT_FRAME) begin
							started_q <= 1'b1;
							t_q       <= t_eff;
							if (count_q != '1) begin
								count_q <= count_q + 1'b1;
							end
							sum_q <= sum_add[TIME_W] ? '1 : sum_add[TIME_W-1:0];
							if (TIME_W'(t_eff) < short_q) begin
								short_q <= TIME_W'(t_eff);
							end
							if (TIME_W'(t_eff) > long_q) begin
								long_q <= TIME_W'(t_eff);
							end
							state_q <= ideal_ok_q ? S_F_T : S_F_IDEAL;
						end else begin
							prod_q <= PROD_W'(count_q) * PROD_W'(Q8_MICROS);
							if (count_q == '0) begin
								res_avg_q <= '0;
								res_min_q <= '0;
								res_max_q <= '0;
								res_jit_q <= '0;
								state_q   <= S_R_OUT;
							end else begin
								state_q <= S_R_MIN;
							end
						end
					end
				end
				S_F_IDEAL: begin
					if (div_done) begin
						ideal_fps_q <= dq_q[OUT_W-1:0];
						ideal_ok_q  <= 1'b1;
						state_q     <= S_F_T;
					end
				end
				S_F_T: begin
					if (div_done) begin
						b_q     <= dq_q[OUT_W-1:0];
						state_q <= S_F_JIT;
					end
				end
				S_F_JIT: begin
					jit_q   <= jit_add[JIT_W] ? '1 : jit_add[JIT_W-1:0];
					state_q <= S_IDLE;
				end
				S_R_MIN: begin
					if (div_done) begin
						res_min_q <= q_sat;
						state_q   <= S_R_MAX;
					end
				end
				S_R_MAX: begin
					if (div_done) begin
						res_max_q <= q_sat;
						state_q   <= S_R_AVG;
					end
				end
				S_R_AVG: begin
					if (div_done) begin
						res_avg_q <= q_sat;
						state_q   <= S_R_JIT;
					end
				end
				S_R_JIT: begin
					if (div_done) begin
						res_jit_q <= q_sat;
						state_q   <= S_R_OUT;
					end
				end
				S_R_OUT: begin
					if (out_free) begin
						avg_out_q   <= res_avg_q;
						min_out_q   <= res_min_q;
						max_out_q   <= res_max_q;
						jit_out_q   <= res_jit_q;
						out_valid_q <= 1'b1;
						count_q     <= '0;
						sum_q       <= '0;
						short_q     <= '1;
						long_q      <= '0;
						jit_q       <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign average_fps = avg_out_q;
	assign minimum_fps = min_out_q;
	assign maximum_fps = max_out_q;
	assign jitter_fps  = jit_out_q;

endmodule

// File: src/frsu_checker.sv
`timescale 1ns / 1ps

`include "frame_rate_statistics_unit_macros.svh"

module frsu_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       action,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [frsu_pkg::OUT_W-1:0] average_fps,
	input logic [frsu_pkg::OUT_W-1:0] minimum_fps,
	input logic [frsu_pkg::OUT_W-1:0] maximum_fps,
	input logic [frsu_pkg::OUT_W-1:0] jitter_fps
);
	import frsu_pkg::*;

	`FRSU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "item dropped while stalled")
	`FRSU_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(average_fps) && $stable(minimum_fps) && $stable(maximum_fps) && $stable(jitter_fps), "stalled item changed")
	// slowest frame can never give a higher rate than the fastest
	`FRSU_ASSERT_NOW(a_min_le_max, out_valid, minimum_fps <= maximum_fps, "minimum fps above maximum fps")
	`FRSU_ASSERT_NEXT(a_frame_busy, in_valid && !in_stall && action == ACT_FRAME, in_stall, "frame item not held for division")
	`FRSU_ASSERT_NEXT(a_frame_silent, in_valid && !in_stall && action == ACT_FRAME && !out_valid, !out_valid, "frame item produced a result")

endmodule

bind frame_rate_statistics_unit frsu_checker u_frsu_checker (.*);
